/* sv/ofec_bi_pkg.sv */
// Shared types, constants and the row-slot table of the block interleaver.
package ofec_bi_pkg;

  localparam int MaxTileRows = 8;
  localparam int MaxTileCols = 8;
  localparam int TileSize    = 16;
  localparam int TileArea    = TileSize * TileSize;
  localparam int StoreDepth  = MaxTileRows * MaxTileCols * TileArea;
  localparam int AddrBits    = $clog2(StoreDepth);
  localparam int SymBits     = 8;

  // Result queue of the back end; depth must be a power of two
  localparam int OutDepth    = 4;
  localparam int OutPtrBits  = $clog2(OutDepth);

  // Status codes of a result word
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  // Register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Operation codes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_REJECT
  } cmd_kind_t;

  // One classified word passed from the front to the back
  typedef struct packed {
    cmd_kind_t           kind;
    logic [AddrBits-1:0] addr;
    logic [SymBits-1:0]  sym;
    logic                frame_end;
    logic [1:0]          status;
  } cmd_t;

  // Result word as it leaves the block
  typedef struct packed {
    logic [SymBits-1:0] sym;
    logic               frame_end;
    logic [1:0]         status;
  } result_t;

  // Tile row per slot, indexed [rows-1][slot]
  typedef logic [7:0][7:0][2:0] slot_tab_t;

  function automatic slot_tab_t build_slot_tab();
    slot_tab_t tab;
    int        half;
    int        count;
    int        base;
    int        top;
    int        first;
    int        r;
    tab = '0;
    for (int rows = 1; rows <= 8; rows++) begin
      half  = rows / 2;
      count = 0;
      for (int t = 0; t < rows; t++) begin
        for (int set = 0; set < 4; set++) begin
          base  = (set < 2) ? 0 : half;
          top   = (set < 2) ? half : rows;
          first = base + (((base % 2) != (set % 2)) ? 1 : 0);
          r     = first + 2 * t;
          if (r < top) begin
            tab[rows-1][count] = 3'(r);
            count++;
          end
        end
      end
    end
    return tab;
  endfunction

  localparam slot_tab_t SLOT_ROW = build_slot_tab();

endpackage

/* sv/ofec_bi_front.sv */
// Front end: config registers, frame counters, word classification and addressing.
module ofec_bi_front import ofec_bi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [3:0]   cfg_data,
  input  logic         accept,
  input  logic         op,
  input  logic [7:0]   symbol_in,
  output cmd_t         cmd
);

  logic [3:0]  rows_r, cols_r;
  logic [14:0] write_count_r, write_count_nxt;
  logic        frame_full_r, frame_full_nxt;
  logic [6:0]  col_r, col_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [3:0]  trow_r, trow_nxt;

  logic [2:0]  rows_m1, cols_m1;
  logic [3:0]  rows_eff, cols_eff;
  logic [7:0]  tile_count;
  logic [14:0] total;
  logic [2:0]  row;
  logic [3:0]  c4;
  logic        b;
  logic [3:0]  srow, scol;
  logic [6:0]  row_base;
  logic [5:0]  tile_idx;

  // Saturate the raw register values into 1..8
  always_comb begin
    rows_m1 = (rows_r == 4'd0) ? 3'd0 : (rows_r > 4'd8) ? 3'd7 : 3'(rows_r - 4'd1);
    cols_m1 = (cols_r == 4'd0) ? 3'd0 : (cols_r > 4'd8) ? 3'd7 : 3'(cols_r - 4'd1);
    rows_eff = {1'b0, rows_m1} + 4'd1;
    cols_eff = {1'b0, cols_m1} + 4'd1;
    tile_count = {4'd0, rows_eff} * {4'd0, cols_eff};
    total = {tile_count[6:0], 8'd0};
  end

  // Interleaved read address
  always_comb begin
    row      = SLOT_ROW[rows_m1][slot_r];
    c4       = col_r[3:0];
    b        = trow_r[3];
    srow     = c4 - {trow_r[2:0], 1'b0} - {3'd0, b};
    scol     = c4 - trow_r - {3'd0, b};
    row_base = {4'd0, row} * {3'd0, cols_eff};
    tile_idx = 6'(row_base + {4'd0, col_r[6:4]});
  end

  // Classify the word and advance the frame counters
  always_comb begin
    write_count_nxt = write_count_r;
    frame_full_nxt  = frame_full_r;
    col_nxt         = col_r;
    slot_nxt        = slot_r;
    trow_nxt        = trow_r;
    cmd.kind        = CMD_REJECT;
    cmd.addr        = {tile_idx, srow, scol};
    cmd.sym         = symbol_in;
    cmd.frame_end   = 1'b0;
    cmd.status      = STATUS_OK;
    if (op == OP_WRITE) begin
      if (frame_full_r || write_count_r >= total) begin
        cmd.status = STATUS_OVERFLOW;
      end else begin
        cmd.kind        = CMD_WRITE;
        cmd.addr        = write_count_r[AddrBits-1:0];
        write_count_nxt = write_count_r + 15'd1;
        if (write_count_nxt == total) begin
          frame_full_nxt = 1'b1;
        end
      end
    end else if (!frame_full_r) begin
      cmd.status = STATUS_UNDERFLOW;
    end else begin
      cmd.kind = CMD_READ;
      trow_nxt = trow_r + 4'd1;
      if (trow_r == 4'hF) begin
        slot_nxt = slot_r + 3'd1;
        if (slot_r == rows_m1) begin
          slot_nxt = '0;
          col_nxt  = col_r + 7'd1;
          if (col_r == {cols_m1, 4'hF}) begin
            cmd.frame_end   = 1'b1;
            col_nxt         = '0;
            write_count_nxt = '0;
            frame_full_nxt  = 1'b0;
          end
        end
      end
    end
  end

  // Hold config and counters; a config write abandons the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r        <= 4'd8;
      cols_r        <= 4'd8;
      write_count_r <= '0;
      frame_full_r  <= 1'b0;
      col_r         <= '0;
      slot_r        <= '0;
      trow_r        <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS) begin
        rows_r <= cfg_data;
      end else begin
        cols_r <= cfg_data;
      end
      write_count_r <= '0;
      frame_full_r  <= 1'b0;
      col_r         <= '0;
      slot_r        <= '0;
      trow_r        <= '0;
    end else if (accept) begin
      write_count_r <= write_count_nxt;
      frame_full_r  <= frame_full_nxt;
      col_r         <= col_nxt;
      slot_r        <= slot_nxt;
      trow_r        <= trow_nxt;
    end
  end

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    frame_full_r |-> (write_count_r == total))
    else $error("frame full with short write count");
  a_idle_read_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_full_r |-> (col_r == '0 && slot_r == '0 && trow_r == '0))
    else $error("read position moved before frame full");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) || $past(!rst_n) || slot_r <= rows_m1)
    else $error("row slot beyond frame rows");

endmodule

/* sv/ofec_bi_cmd_queue.sv */
// Two-word queue of classified words between the front and the back.
module ofec_bi_cmd_queue import ofec_bi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic q_full,
  output logic q_empty,
  input  logic rd_en,
  output cmd_t rd_cmd
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign rd_cmd  = slot_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

/* sv/ofec_bi_back.sv */
// Back end: symbol store, read stage and result queue.
module ofec_bi_back import ofec_bi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_empty,
  input  cmd_t         cmd,
  output logic         cmd_pop,
  output logic         empty,
  input  logic         pop,
  output result_t      result
);

  logic [SymBits-1:0] mem [StoreDepth];
  logic [SymBits-1:0] mem_q_r;

  logic       s1_valid_r;
  logic       s1_read_r;
  logic       s1_end_r;
  logic [1:0] s1_status_r;

  result_t                outq_r [OutDepth];
  logic [OutPtrBits-1:0]  out_wr_r, out_rd_r;
  logic [OutPtrBits:0]    out_count_r;
  logic [OutPtrBits+1:0]  out_used;
  logic                   out_pop;
  result_t                s1_res;

  // Take a command only when the result queue has room for it
  assign out_used = {1'b0, out_count_r} + (OutPtrBits+2)'(s1_valid_r);
  assign cmd_pop  = !cmd_empty && (out_used < (OutPtrBits+2)'(OutDepth));
  assign empty    = (out_count_r == '0);
  assign out_pop  = pop && !empty;
  assign result   = outq_r[out_rd_r];

  // Symbol store with registered read
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_WRITE) begin
      mem[cmd.addr] <= cmd.sym;
    end
    if (cmd_pop) begin
      mem_q_r <= mem[cmd.addr];
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd_pop;
    end
    if (cmd_pop) begin
      s1_read_r   <= (cmd.kind == CMD_READ);
      s1_end_r    <= cmd.frame_end;
      s1_status_r <= cmd.status;
    end
  end

  always_comb begin
    s1_res.sym       = s1_read_r ? mem_q_r : '0;
    s1_res.frame_end = s1_end_r;
    s1_res.status    = s1_status_r;
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      outq_r[out_wr_r] <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_r    <= '0;
      out_rd_r    <= '0;
      out_count_r <= '0;
    end else begin
      if (s1_valid_r) begin
        out_wr_r <= out_wr_r + OutPtrBits'(1);
      end
      if (out_pop) begin
        out_rd_r <= out_rd_r + OutPtrBits'(1);
      end
      out_count_r <= out_count_r + (OutPtrBits+1)'(s1_valid_r)
                     - (OutPtrBits+1)'(out_pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (out_count_r < (OutPtrBits+1)'(OutDepth) || out_pop))
    else $error("read stage pushed into a full result queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_count_r <= (OutPtrBits+1)'(OutDepth))
    else $error("result queue count out of range");
  a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_end_r) |-> (s1_read_r && s1_status_r == STATUS_OK))
    else $error("frame end on a word that is not a good read");

endmodule

/* sv/ofec_block_interleaver.sv */
// Top level of the 16x16-tile block interleaver.
// Stores one frame of block_rows*block_cols*256 symbols in input order; once
// full, reads return it in interleaved order and the last read (frame_end)
// frees the frame. Every input word yields one result word with a status:
// ok, overflow (write to a full frame, dropped) or underflow (read before the
// frame is full, symbol 0). Input words are taken one per clock while not
// full: the front end classifies and addresses each word, a two-word queue
// feeds the back end, which does one store access per cycle while the result
// queue has room, and results pass a read stage to the output queue. Sustained
// rate is one word per clock on both sides, bounded by the single store port.
// Writing either config register abandons the current frame.
module ofec_block_interleaver import ofec_bi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic       in_op,
  input  logic [7:0] in_symbol_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_symbol_out,
  output logic       out_frame_end,
  output logic [1:0] out_status
);

  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    accept;
  logic    q_empty;
  logic    cmd_pop;
  result_t result;

  assign accept = push && !full;

  ofec_bi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (in_op),
    .symbol_in (in_symbol_in),
    .cmd       (front_cmd)
  );

  ofec_bi_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_cmd  (front_cmd),
    .q_full  (full),
    .q_empty (q_empty),
    .rd_en   (cmd_pop),
    .rd_cmd  (head_cmd)
  );

  ofec_bi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign out_symbol_out = result.sym;
  assign out_frame_end  = result.frame_end;
  assign out_status     = result.status;

endmodule
